[hw/rtl/assert_macros.svh]
// Assertion helpers for the block's concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Antecedent on one edge implies consequent on the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/lz4d_pkg.sv]
// ----------------------------------------------------------------------------
// lz4d_pkg
// Shared types and constants of the LZ4 block decoder.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  localparam int unsigned HISTORY_DEPTH = 65536;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned CMDQ_DEPTH    = 2;

  localparam logic [3:0] NIB_EXT   = 4'd15;
  localparam logic [7:0] BYTE_EXT  = 8'd255;
  localparam logic [3:0] MIN_MATCH = 4'd4;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TRUNC_LIT  = 3'd1,
    ERR_LIT_OVR    = 3'd2,
    ERR_OUT_OVF    = 3'd3,
    ERR_TRUNC_OFF  = 3'd4,
    ERR_BAD_OFF    = 3'd5,
    ERR_TRUNC_MLEN = 3'd6,
    ERR_SIZE       = 3'd7
  } err_e;

  // Classified command passed from front to back.
  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] size;
  } cmd_t;

endpackage

[hw/rtl/lz4d_ram.sv]
// ----------------------------------------------------------------------------
// lz4d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lz4d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/lz4d_front.sv]
// ----------------------------------------------------------------------------
// lz4d_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lz4d_front import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic [31:0] expected_size_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);

  cmd_t         slot_q [CMDQ_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;
  cmd_t          cls;
  logic          push, pop;

  always_comb begin
    cls.data = data_byte_i;
    cls.last = is_last_i;
    cls.size = expected_size_i;
    case (cmd_i)
      CMD_START: cls.kind = CMD_START;
      CMD_BYTE:  cls.kind = CMD_BYTE;
      CMD_TICK:  cls.kind = CMD_TICK;
      default:   cls.kind = CMD_NOP;
    endcase
  end

  assign in_ready_o = (cnt_q != (PW+1)'(CMDQ_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_cmd_o    = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PW'(1);
      if (pop)  rptr_q <= rptr_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

[hw/rtl/lz4d_back.sv]
// ----------------------------------------------------------------------------
// lz4d_back
// Sequence parser, history store and output stage.
// ----------------------------------------------------------------------------
module lz4d_back import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        copy_pending_o,
  output logic        done_res_o,
  output logic [3:0]  error_code_o
);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITLEN, PH_LITERAL, PH_LITSKIP,
    PH_OFFLO, PH_OFFHI, PH_MATLEN, PH_COPY
  } phase_e;

  // Parser state
  logic [31:0] out_cnt_q, out_cnt_d;
  logic [31:0] room_q, room_d;       // expected size minus bytes out
  phase_e      ph_q, ph_d;
  logic [31:0] lit_q, lit_d;
  logic [31:0] ml_q, ml_d;
  logic [15:0] off_q, off_d;
  logic [3:0]  nib_q, nib_d;
  logic        end_q, end_d;
  err_e        err_q, err_d;

  // Second stage
  logic             s2_valid_q, s2_copy_q, s2_bv_q, s2_hit_q;
  logic [7:0]       s2_lit_q, s2_fwd_q;
  logic [HIST_AW-1:0] s2_waddr_q;
  logic             s2_cp_q, s2_done_q;
  logic [2:0]       s2_err_q;

  // Output register
  logic       o_valid_q;
  logic [7:0] o_byte_q;
  logic       o_bv_q, o_cp_q, o_done_q;
  logic [2:0] o_err_q;

  logic e_go, s2_adv, e_lit, e_copy, active;
  logic [HIST_AW-1:0] raddr;
  logic [7:0] ram_rdata, s2_byte;
  logic ram_we;

  logic [32:0] lit_sum;
  logic [31:0] lit_sat, lit_cand, m_cand, ml_sat;
  logic [32:0] ml_sum;
  logic [33:0] m_sum;
  logic        ext;
  logic [7:0]  v;

  assign s2_adv = s2_valid_q && (!o_valid_q || out_ready_i);
  assign e_go   = q_valid_i && (!s2_valid_q || s2_adv);
  assign q_pop_o = e_go;

  assign v       = q_cmd_i.data;
  assign lit_sum = {1'b0, lit_q} + 33'(v);
  assign lit_sat = lit_sum[32] ? '1 : lit_sum[31:0];
  assign ml_sum  = {1'b0, ml_q} + 33'(v);
  assign ml_sat  = ml_sum[32] ? '1 : ml_sum[31:0];
  assign m_sum   = {2'b0, ml_q} + 34'(v) + 34'(MIN_MATCH);
  assign raddr   = out_cnt_q[HIST_AW-1:0] - HIST_AW'(off_q);
  assign active  = (err_q == ERR_NONE) && !(end_q && ph_q != PH_COPY);

  always_comb begin
    out_cnt_d = out_cnt_q;
    room_d    = room_q;
    ph_d      = ph_q;
    lit_d     = lit_q;
    ml_d      = ml_q;
    off_d     = off_q;
    nib_d     = nib_q;
    end_d     = end_q;
    err_d     = err_q;
    e_lit     = 1'b0;
    e_copy    = 1'b0;
    ext       = 1'b0;
    lit_cand  = '0;
    m_cand    = '0;
    case (q_cmd_i.kind)
      CMD_START: begin
        out_cnt_d = '0;
        room_d    = q_cmd_i.size;
        ph_d      = PH_TOKEN;
        lit_d     = '0;
        ml_d      = '0;
        off_d     = '0;
        nib_d     = '0;
        end_d     = 1'b0;
        err_d     = ERR_NONE;
      end
      CMD_BYTE: begin
        if (active && ph_q != PH_COPY) begin
          case (ph_q)
            PH_TOKEN, PH_LITLEN: begin
              if (ph_q == PH_TOKEN) begin
                nib_d    = v[3:0];
                lit_cand = 32'(v[7:4]);
                ext      = (v[7:4] == NIB_EXT);
              end else begin
                lit_cand = lit_sat;
                ext      = (v == BYTE_EXT);
              end
              lit_d = lit_cand;
              if (ext) begin
                if (q_cmd_i.last) begin
                  err_d = ERR_TRUNC_LIT; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
                end else begin
                  ph_d = PH_LITLEN;
                end
              end else if (q_cmd_i.last) begin
                if (lit_cand == '0) begin
                  end_d = 1'b1; ph_d = PH_TOKEN;
                  if (room_q != '0) err_d = ERR_SIZE;
                end else begin
                  err_d = ERR_LIT_OVR; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
                end
              end else if (lit_cand > room_q) begin
                ph_d = PH_LITSKIP;
              end else if (lit_cand != '0) begin
                ph_d = PH_LITERAL;
              end else begin
                ph_d = PH_OFFLO;
              end
            end
            PH_LITERAL: begin
              e_lit     = 1'b1;
              out_cnt_d = out_cnt_q + 32'd1;
              room_d    = room_q - 32'd1;
              lit_d     = lit_q - 32'd1;
              if (lit_q == 32'd1) begin
                if (q_cmd_i.last) begin
                  end_d = 1'b1; ph_d = PH_TOKEN;
                  if (room_d != '0) err_d = ERR_SIZE;
                end else begin
                  ph_d = PH_OFFLO;
                end
              end else if (q_cmd_i.last) begin
                err_d = ERR_LIT_OVR; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end
            end
            PH_LITSKIP: begin
              lit_d = lit_q - 32'd1;
              if (lit_q == 32'd1) begin
                err_d = ERR_OUT_OVF; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end else if (q_cmd_i.last) begin
                err_d = ERR_LIT_OVR; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end
            end
            PH_OFFLO: begin
              if (q_cmd_i.last) begin
                err_d = ERR_TRUNC_OFF; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end else begin
                off_d = {8'd0, v};
                ph_d  = PH_OFFHI;
              end
            end
            default: begin  // offset high byte or match length byte
              if (ph_q == PH_OFFHI) begin
                off_d  = {v, off_q[7:0]};
                m_cand = 32'(nib_q) + 32'(MIN_MATCH);
                ext    = (nib_q == NIB_EXT);
              end else begin
                ml_d   = ml_sat;
                m_cand = |m_sum[33:32] ? '1 : m_sum[31:0];
                ext    = (v == BYTE_EXT);
              end
              if (ph_q == PH_OFFHI &&
                  (off_d == '0 || 32'(off_d) > out_cnt_q)) begin
                err_d = ERR_BAD_OFF; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end else if (ext) begin
                if (q_cmd_i.last) begin
                  err_d = ERR_TRUNC_MLEN; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
                end else begin
                  if (ph_q == PH_OFFHI) ml_d = 32'(NIB_EXT);
                  ph_d = PH_MATLEN;
                end
              end else if (m_cand > room_q) begin
                err_d = ERR_OUT_OVF; end_d = 1'b1; ml_d = '0; ph_d = PH_TOKEN;
              end else begin
                ml_d  = m_cand;
                ph_d  = PH_COPY;
                end_d = q_cmd_i.last;
              end
            end
          endcase
        end
      end
      CMD_TICK: begin
        if (active && ph_q == PH_COPY) begin
          e_copy    = 1'b1;
          out_cnt_d = out_cnt_q + 32'd1;
          room_d    = room_q - 32'd1;
          ml_d      = ml_q - 32'd1;
          if (ml_q == 32'd1) begin
            ph_d = PH_TOKEN;
            if (end_q && room_d != '0) err_d = ERR_SIZE;
          end
        end
      end
      default: ;
    endcase
  end

  assign s2_byte = !s2_copy_q ? s2_lit_q : (s2_hit_q ? s2_fwd_q : ram_rdata);
  assign ram_we  = s2_adv && s2_bv_q;

  lz4d_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_waddr_q),
    .wdata_i (s2_byte),
    .re_i    (e_go),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q  <= '0;
      room_q     <= '0;
      ph_q       <= PH_TOKEN;
      lit_q      <= '0;
      ml_q       <= '0;
      off_q      <= '0;
      nib_q      <= '0;
      end_q      <= 1'b0;
      err_q      <= ERR_NONE;
      s2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
      o_byte_q   <= '0;
      o_bv_q     <= 1'b0;
      o_cp_q     <= 1'b0;
      o_done_q   <= 1'b0;
      o_err_q    <= '0;
    end else begin
      if (e_go) begin
        out_cnt_q <= out_cnt_d;
        room_q    <= room_d;
        ph_q      <= ph_d;
        lit_q     <= lit_d;
        ml_q      <= ml_d;
        off_q     <= off_d;
        nib_q     <= nib_d;
        end_q     <= end_d;
        err_q     <= err_d;
      end
      if (e_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        o_valid_q <= 1'b1;
        o_byte_q  <= s2_bv_q ? s2_byte : 8'd0;
        o_bv_q    <= s2_bv_q;
        o_cp_q    <= s2_cp_q;
        o_done_q  <= s2_done_q;
        o_err_q   <= s2_err_q;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Stage-two payload; forward the byte written in the read cycle
  always_ff @(posedge clk_i) begin
    if (e_go) begin
      s2_copy_q  <= e_copy;
      s2_bv_q    <= e_lit || e_copy;
      s2_lit_q   <= v;
      s2_waddr_q <= out_cnt_q[HIST_AW-1:0];
      s2_hit_q   <= ram_we && (s2_waddr_q == raddr);
      s2_fwd_q   <= s2_byte;
      s2_cp_q    <= (err_d == ERR_NONE) && (ph_d == PH_COPY);
      s2_done_q  <= end_d && (err_d == ERR_NONE) && (ph_d != PH_COPY);
      s2_err_q   <= err_d;
    end
  end

  assign out_valid_o    = o_valid_q;
  assign out_byte_o     = o_byte_q;
  assign byte_valid_o   = o_bv_q;
  assign copy_pending_o = o_cp_q;
  assign done_res_o     = o_done_q;
  assign error_code_o   = {1'b0, o_err_q};

endmodule

[hw/rtl/lz4_block_decoder.sv]
// ----------------------------------------------------------------------------
// lz4_block_decoder
// Streaming LZ4 block decoder: one command in, one status item out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid_i/in_ready_o | cmd_i, data_byte_i, is_last_i, expected_size_i
//  out     | out_valid_o/out_ready_i | out_byte_o, byte_valid_o, copy_pending_o,
//          |                       | done_res_o, error_code_o
//
//  One command per cycle sustained while out_ready_i is high; each result
//  passes through the command queue, the parse stage with the registered
//  read of the 64 KiB history RAM, and the output register.
//  Reset is asynchronous; history contents are not cleared (never read unwritten).
//  Stalls on the output back up through the two-entry command queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz4_block_decoder import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic [31:0] expected_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        copy_pending_o,
  output logic        done_res_o,
  output logic [3:0]  error_code_o
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Front end: classify and buffer commands
  lz4d_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .data_byte_i,
    .is_last_i, .expected_size_i,
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd),
    .q_pop_i   (q_pop)
  );

  // Back end: parser, history copy, output register
  lz4d_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i, .out_byte_o, .byte_valid_o,
    .copy_pending_o, .done_res_o, .error_code_o
  );

  `ASSERT_ALWAYS(a_done_not_pending, clk_i, rst_ni, !(done_res_o && copy_pending_o))
  `ASSERT_ALWAYS(a_err_quiet, clk_i, rst_ni,
                 (error_code_o == 4'd0) || (!done_res_o && !copy_pending_o))
  `ASSERT_ALWAYS(a_byte_zero, clk_i, rst_ni, byte_valid_o || (out_byte_o == 8'd0))
  `ASSERT_NEXT(a_err_hold, clk_i, rst_ni,
               out_valid_o && !out_ready_i, $stable(error_code_o))

endmodule

[tb/lz4_block_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz4_block_decoder_tb
// Streams LZ4 blocks, mostly well-formed with random content plus corrupted
// and noisy ones, through the decoder and checks every status transfer
// against a cycle-free model of the decoder kept in this bench.
// ----------------------------------------------------------------------------
module lz4_block_decoder_tb;
  import lz4d_pkg::*;

  localparam int IDLE_LIMIT = 4000;   // cycles without any transfer
  localparam int LONG_HOLD  = 400;    // long back-pressure stretch
  localparam int QUIET_TAIL = 60;     // no idling over the last items

  typedef enum logic [2:0] {
    P_TOKEN, P_LITLEN, P_LITERAL, P_LITSKIP, P_OFFLO, P_OFFHI, P_MATLEN, P_COPY
  } phase_e;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  b;
    logic        last;
    logic [31:0] size;
    bit          hold;   // wait until every status has come before sending
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       bv;
    logic       cp;
    logic       dn;
    logic [3:0] ec;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = CMD_NOP;
  logic [7:0]  data_byte_i = '0;
  logic        is_last_i = 1'b0;
  logic [31:0] expected_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o, copy_pending_o, done_res_o;
  logic [3:0]  error_code_o;

  always #5 clk_i = ~clk_i;

  lz4_block_decoder dut (.*);

  // --------------------------------------------------------------------------
  // Decoder model state
  // --------------------------------------------------------------------------
  logic [7:0]  hist [HISTORY_DEPTH];
  logic [31:0] n_out, n_exp, lit_left, mat_left;
  logic [15:0] m_off;
  logic [3:0]  m_nib;
  logic        ended;
  err_e        err;
  phase_e      ph;

  cmd_item_t pend_q[$];
  status_t   status_q[$];
  int        n_fail = 0;
  int        n_in = 0;
  bit        gen_done = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit overflows(logic [31:0] len);
    return ({1'b0, n_out} + {1'b0, len}) > {1'b0, n_exp};
  endfunction

  task automatic abort_block(err_e e);
    err = e; ended = 1'b1; mat_left = '0; ph = P_TOKEN;
  endtask

  task automatic close_block();
    ended = 1'b1; ph = P_TOKEN;
    if (n_out != n_exp) err = ERR_SIZE;
  endtask

  task automatic store_byte(logic [7:0] b);
    hist[n_out[15:0]] = b;
    n_out++;
  endtask

  task automatic literal_len_known(logic [31:0] len, logic last);
    if (last) begin
      if (len == 0) close_block();
      else abort_block(ERR_LIT_OVR);
    end else begin
      lit_left = len;
      if (overflows(len)) ph = P_LITSKIP;
      else if (len > 0) ph = P_LITERAL;
      else ph = P_OFFLO;
    end
  endtask

  task automatic match_len_known(logic [31:0] len, logic last);
    if (overflows(len)) begin
      abort_block(ERR_OUT_OVF);
    end else begin
      mat_left = len; ph = P_COPY; ended = last;
    end
  endtask

  // Works out the status transfer caused by one accepted command.
  task automatic decode_cmd(input cmd_item_t it, output status_t st);
    logic       active;
    logic       bv;
    logic [7:0] ob;
    active = (err == ERR_NONE) && !(ended && ph != P_COPY);
    bv = 1'b0; ob = '0;
    if (it.cmd == CMD_START) begin
      n_out = '0; n_exp = it.size; ph = P_TOKEN; lit_left = '0; mat_left = '0;
      m_off = '0; m_nib = '0; ended = 1'b0; err = ERR_NONE;
    end else if (it.cmd == CMD_BYTE && active && ph != P_COPY) begin
      case (ph)
        P_TOKEN: begin
          m_nib = it.b[3:0];
          if (it.b[7:4] == NIB_EXT) begin
            if (it.last) abort_block(ERR_TRUNC_LIT);
            else begin lit_left = 32'(NIB_EXT); ph = P_LITLEN; end
          end else literal_len_known(32'(it.b[7:4]), it.last);
        end
        P_LITLEN: begin
          lit_left = sat_add(lit_left, 32'(it.b));
          if (it.b == BYTE_EXT) begin
            if (it.last) abort_block(ERR_TRUNC_LIT);
          end else literal_len_known(lit_left, it.last);
        end
        P_LITERAL: begin
          bv = 1'b1; ob = it.b;
          store_byte(it.b);
          lit_left--;
          if (lit_left == 0) begin
            if (it.last) close_block();
            else ph = P_OFFLO;
          end else if (it.last) abort_block(ERR_LIT_OVR);
        end
        P_LITSKIP: begin
          lit_left--;
          if (lit_left == 0) abort_block(ERR_OUT_OVF);
          else if (it.last) abort_block(ERR_LIT_OVR);
        end
        P_OFFLO: begin
          if (it.last) abort_block(ERR_TRUNC_OFF);
          else begin m_off = {8'h00, it.b}; ph = P_OFFHI; end
        end
        P_OFFHI: begin
          m_off[15:8] = it.b;
          if (m_off == 0 || 32'(m_off) > n_out) abort_block(ERR_BAD_OFF);
          else if (m_nib == NIB_EXT) begin
            if (it.last) abort_block(ERR_TRUNC_MLEN);
            else begin mat_left = 32'(NIB_EXT); ph = P_MATLEN; end
          end else match_len_known(32'(m_nib) + 32'(MIN_MATCH), it.last);
        end
        P_MATLEN: begin
          mat_left = sat_add(mat_left, 32'(it.b));
          if (it.b == BYTE_EXT) begin
            if (it.last) abort_block(ERR_TRUNC_MLEN);
          end else match_len_known(sat_add(mat_left, 32'(MIN_MATCH)), it.last);
        end
        default: ;
      endcase
    end else if (it.cmd == CMD_TICK && active && ph == P_COPY) begin
      // source may overlap the bytes being written
      ob = hist[n_out[15:0] - m_off];
      bv = 1'b1;
      store_byte(ob);
      mat_left--;
      if (mat_left == 0) begin
        if (ended) close_block();
        else ph = P_TOKEN;
      end
    end
    st.ob = ob;
    st.bv = bv;
    st.cp = (err == ERR_NONE) && (ph == P_COPY);
    st.dn = ended && (err == ERR_NONE) && (ph != P_COPY);
    st.ec = {1'b0, err};
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  task automatic push(cmd_e c, logic [7:0] b = 8'h00, logic l = 1'b0,
                      logic [31:0] sz = '0, bit hold = 0);
    cmd_item_t it;
    it.cmd = c; it.b = b; it.last = l; it.size = sz; it.hold = hold;
    pend_q = {pend_q, it};
  endtask

  // Builds one block: sequences of literals and matches with random content,
  // sometimes with a wrong size, a corrupted byte or stray commands.
  task automatic gen_block();
    cmd_item_t blk[$];
    cmd_item_t it;
    int n_seq, lit, mlen, made, off, nib, ext, pos;
    bit end_on_match;
    n_seq = $urandom_range(1, 4);
    made = 0;
    it.hold = 0; it.size = '0; it.last = 0;
    for (int s = 0; s < n_seq; s++) begin
      bit final_seq;
      final_seq = (s == n_seq - 1);
      end_on_match = final_seq && made > 0 && ($urandom_range(0, 2) == 0);
      lit = ($urandom_range(0, 29) == 0) ? $urandom_range(15, 300) : $urandom_range(0, 14);
      if (made == 0 && !final_seq && lit == 0) lit = 1;
      if (final_seq && !end_on_match) begin
        // closing literal run
        nib = 0;
      end else nib = $urandom_range(0, 15);
      it.cmd = CMD_BYTE; it.last = 0;
      it.b = {(lit >= 15) ? 4'hF : 4'(lit), 4'(nib)};
      blk = {blk, it};
      if (lit >= 15) begin
        ext = lit - 15;
        while (ext >= 255) begin it.b = 8'hFF; blk = {blk, it}; ext -= 255; end
        it.b = 8'(ext); blk = {blk, it};
      end
      for (int i = 0; i < lit; i++) begin
        it.b = 8'($urandom); blk = {blk, it};
      end
      made += lit;
      if (final_seq && !end_on_match) begin
        blk[$].last = 1'b1;
        break;
      end
      off = $urandom_range(1, (made > 65535) ? 65535 : made);
      it.b = 8'(off); blk = {blk, it};
      it.b = 8'(off >> 8); blk = {blk, it};
      mlen = nib + 4;
      if (nib == 15) begin
        ext = ($urandom_range(0, 19) == 0) ? $urandom_range(255, 300) : $urandom_range(0, 40);
        mlen += ext;
        while (ext >= 255) begin it.b = 8'hFF; blk = {blk, it}; ext -= 255; end
        it.b = 8'(ext); blk = {blk, it};
      end
      if (end_on_match) blk[$].last = 1'b1;
      it.cmd = CMD_TICK; it.b = 8'($urandom); it.last = 1'($urandom);
      for (int i = 0; i < mlen; i++) blk = {blk, it};
      made += mlen;
    end
    // mostly the true size, sometimes off by one or random
    case ($urandom_range(0, 9))
      0: push(CMD_START, 8'($urandom), 1'($urandom), made + 1);
      1: push(CMD_START, 8'($urandom), 1'($urandom), (made > 0) ? made - 1 : 0);
      2: push(CMD_START, 8'($urandom), 1'($urandom), $urandom_range(0, made));
      3: push(CMD_START, 8'($urandom), 1'($urandom), $urandom);
      default: push(CMD_START, 8'($urandom), 1'($urandom), made);
    endcase
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, blk.size() - 1);
      if (blk[pos].cmd == CMD_BYTE) begin
        blk[pos].b = 8'($urandom);
        blk[pos].last = 1'($urandom);
      end
    end
    foreach (blk[i]) begin
      if ($urandom_range(0, 24) == 0)
        push(($urandom_range(0, 1) != 0) ? CMD_NOP : CMD_TICK, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 14) == 0 && blk[i].cmd == CMD_TICK)
        push(CMD_BYTE, 8'($urandom), 1'($urandom));   // byte during a pending match
      pend_q = {pend_q, blk[i]};
    end
    // stray commands after the end are ignored
    if ($urandom_range(0, 4) == 0) push(CMD_BYTE, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    // Directed: literals only, including the byte extremes, exact size
    push(CMD_START, 8'h00, 1'b0, 32'd3);
    push(CMD_BYTE, 8'h30); push(CMD_BYTE, 8'h00); push(CMD_BYTE, 8'hFF);
    push(CMD_BYTE, 8'hA5, 1'b1);
    push(CMD_BYTE, 8'h11, 1'b1);                 // after the end: ignored
    // overlapping match (offset 1), ended on the offset byte
    push(CMD_START, 8'hFF, 1'b1, 32'd5);
    push(CMD_BYTE, 8'h10); push(CMD_BYTE, 8'h7E);
    push(CMD_BYTE, 8'h01); push(CMD_BYTE, 8'h00, 1'b1);
    push(CMD_BYTE, 8'h55);                       // byte while match pending
    repeat (4) push(CMD_TICK, 8'h00, 1'b1);
    push(CMD_TICK);                              // tick with nothing pending
    push(CMD_NOP, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1);
    // truncated literal length; maximal expected size
    push(CMD_START, 8'h00, 1'b0, 32'hFFFF_FFFF);
    push(CMD_BYTE, 8'hF0); push(CMD_BYTE, 8'hFF, 1'b1);
    // literal run overruns input
    push(CMD_START, 8'h00, 1'b0, 32'd10);
    push(CMD_BYTE, 8'h20); push(CMD_BYTE, 8'h41, 1'b1);
    // literal run larger than the output
    push(CMD_START, 8'h00, 1'b0, 32'd1);
    push(CMD_BYTE, 8'h20); push(CMD_BYTE, 8'h41); push(CMD_BYTE, 8'h42);
    // truncated offset, then a literal run too large for a zero size
    push(CMD_START, 8'h00, 1'b0, 32'd9);
    push(CMD_BYTE, 8'h10); push(CMD_BYTE, 8'h41); push(CMD_BYTE, 8'h01, 1'b1);
    push(CMD_START, 8'h00, 1'b0, 32'd0);
    push(CMD_BYTE, 8'h10); push(CMD_BYTE, 8'h41);
    push(CMD_BYTE, 8'h00); push(CMD_BYTE, 8'h00);
    // truncated match length
    push(CMD_START, 8'h00, 1'b0, 32'd40);
    push(CMD_BYTE, 8'h1F); push(CMD_BYTE, 8'h41); push(CMD_BYTE, 8'h01);
    push(CMD_BYTE, 8'h00); push(CMD_BYTE, 8'hFF, 1'b1);
    // empty literal run with size mismatch
    push(CMD_START, 8'h00, 1'b0, 32'd2);
    push(CMD_BYTE, 8'h00, 1'b1);

    while (pend_q.size() < 850) begin
      gen_block();
      if (pend_q.size() > 400 && pend_q.size() < 500)
        push(CMD_NOP, 8'h00, 1'b0, '0, 1);      // sender drains the pipe here
    end
    gen_done = 1;
  end

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge
  // --------------------------------------------------------------------------
  bit in_took;
  int in_gap = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() != 0 && !(pend_q[0].hold && status_q.size() != 0)) begin
        cmd_item_t it;
        it = pend_q.pop_front();
        cmd_i <= it.cmd;
        data_byte_i <= it.b;
        is_last_i <= it.last;
        expected_size_i <= it.size;
        in_valid_i <= 1'b1;
        if (pend_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
          in_gap <= $urandom_range(1, 14);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off once traffic is flowing
  int  out_gap = 0;
  bit  long_done = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!long_done && n_in > 200) begin
        long_done <= 1;
        out_gap <= LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (!(gen_done && pend_q.size() <= QUIET_TAIL) && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge, predict and check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      cmd_item_t it;
      status_t   st;
      it.cmd = cmd_e'(cmd_i); it.b = data_byte_i; it.last = is_last_i;
      it.size = expected_size_i; it.hold = 0;
      decode_cmd(it, st);
      status_q = {status_q, st};
      n_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      status_t got, want;
      got = '{out_byte_o, byte_valid_o, copy_pending_o, done_res_o, error_code_o};
      if (status_q.size() == 0) begin
        $display("%0t: status transfer with none expected: %h", $time, got);
        n_fail++;
      end else begin
        want = status_q.pop_front();
        if (got.ob !== want.ob) begin
          $display("%0t: out_byte exp %h got %h", $time, want.ob, got.ob); n_fail++;
        end
        if (got.bv !== want.bv) begin
          $display("%0t: byte_valid exp %b got %b", $time, want.bv, got.bv); n_fail++;
        end
        if (got.cp !== want.cp) begin
          $display("%0t: copy_pending exp %b got %b", $time, want.cp, got.cp); n_fail++;
        end
        if (got.dn !== want.dn) begin
          $display("%0t: done_res exp %b got %b", $time, want.dn, got.dn); n_fail++;
        end
        if (got.ec !== want.ec) begin
          $display("%0t: error_code exp %0d got %0d", $time, want.ec, got.ec); n_fail++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    n_out = '0; n_exp = '0; lit_left = '0; mat_left = '0; m_off = '0; m_nib = '0;
    ended = 1'b0; err = ERR_NONE; ph = P_TOKEN;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (gen_done && pend_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
